// File: rtl/kcl_pkg.sv
// Package: shared types, codes and constants for the keypad code lock.
`timescale 1ns / 1ps
package kcl_pkg;

  localparam int CODE_DIGITS = 4;
  localparam int USER_COUNT  = 4;
  localparam int TIMER_BITS  = 16;
  localparam int CODE_REGS   = 4;

  localparam int CODE_W = 14;
  localparam int TICK_W = 16;
  localparam int CNT_W  = 3;
  localparam int FAIL_W = 4;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [FAIL_W-1:0]     FAIL_MAX  = '1;

  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_STAR       = 4'd10;

  // configuration register indexes
  localparam logic [2:0] CFG_USER_CODE_0 = 3'd0;
  localparam logic [2:0] CFG_USER_CODE_1 = 3'd1;
  localparam logic [2:0] CFG_USER_CODE_2 = 3'd2;
  localparam logic [2:0] CFG_USER_CODE_3 = 3'd3;
  localparam logic [2:0] CFG_ENTRY_TO    = 3'd4;
  localparam logic [2:0] CFG_HOLD        = 3'd5;
  localparam logic [2:0] CFG_LOCKOUT     = 3'd6;
  localparam logic [2:0] CFG_MAX_FAIL    = 3'd7;

  typedef enum logic [1:0] {
    MODE_ENTRY = 2'd0,
    MODE_HOLD  = 2'd1,
    MODE_LOCK  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    MSG_ENTER   = 3'd0,
    MSG_SHOW    = 3'd1,
    MSG_WELCOME = 3'd2,
    MSG_DENIED  = 3'd3,
    MSG_LOCKED  = 3'd4,
    MSG_EMERG   = 3'd5
  } msg_t;

  typedef struct packed {
    logic       key_valid;
    logic [3:0] key_code;
    logic       emergency;
  } item_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [2:0]        message;
    logic [CODE_W-1:0] entered_value;
    logic [CNT_W-1:0]  digit_count;
    logic              door_open;
    logic [1:0]        matched_user;
    logic [FAIL_W-1:0] fail_count;
  } result_t;

  typedef struct packed {
    logic [CODE_REGS-1:0][CODE_W-1:0] user_code;
    logic [TICK_W-1:0]                entry_timeout;
    logic [TICK_W-1:0]                hold;
    logic [TICK_W-1:0]                lockout;
    logic [FAIL_W-1:0]                max_failures;
  } cfg_t;

endpackage

// File: rtl/kcl_cfg_regs.sv
// Configuration register file for the keypad code lock.
`timescale 1ns / 1ps
module kcl_cfg_regs
  import kcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.user_code[0]  <= CODE_W'(6969);
      cfg.user_code[1]  <= CODE_W'(8834);
      cfg.user_code[2]  <= CODE_W'(6767);
      cfg.user_code[3]  <= CODE_W'(1060);
      cfg.entry_timeout <= TICK_W'(7000);
      cfg.hold          <= TICK_W'(3000);
      cfg.lockout       <= TICK_W'(15000);
      cfg.max_failures  <= FAIL_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_USER_CODE_0: cfg.user_code[0]  <= cfg_data[CODE_W-1:0];
        CFG_USER_CODE_1: cfg.user_code[1]  <= cfg_data[CODE_W-1:0];
        CFG_USER_CODE_2: cfg.user_code[2]  <= cfg_data[CODE_W-1:0];
        CFG_USER_CODE_3: cfg.user_code[3]  <= cfg_data[CODE_W-1:0];
        CFG_ENTRY_TO:    cfg.entry_timeout <= cfg_data;
        CFG_HOLD:        cfg.hold          <= cfg_data;
        CFG_LOCKOUT:     cfg.lockout       <= cfg_data;
        CFG_MAX_FAIL:    cfg.max_failures  <= cfg_data[FAIL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/kcl_core.sv
// Lock state registers and the per-tick update that forms each result.
`timescale 1ns / 1ps
module kcl_core
  import kcl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  mode_t                 mode_reg, mode_next;
  msg_t                  last_message, msg_next;
  logic [CODE_W-1:0]     entry_value, value_next;
  logic [CNT_W-1:0]      digits_held, digits_next;
  logic [TIMER_BITS-1:0] elapsed, elapsed_next, elapsed_inc;
  logic [FAIL_W-1:0]     failures, failures_next;
  logic                  outputs_on, on_next;
  logic [1:0]            last_user, user_next;

  logic [17:0]           times_ten;
  logic [29:0]           recip_prod;
  logic [CODE_W-1:0]     value_div10;
  logic [CNT_W-1:0]      digits_add;
  logic [CODE_W-1:0]     value_add;
  logic                  match_found;
  logic [1:0]            match_idx;

  assign elapsed_inc = (elapsed != TIMER_MAX) ? elapsed + 1'b1 : elapsed;

  // v*10 + key, and v/10 by reciprocal (exact for 14-bit values)
  assign times_ten   = ({4'b0, entry_value} << 3) + ({4'b0, entry_value} << 1)
                       + 18'(item.key_code);
  assign recip_prod  = 30'(entry_value) * 30'(16'd52429);
  assign value_div10 = CODE_W'(recip_prod[29:19]);

  assign digits_add = (digits_held < CNT_W'(CODE_DIGITS)) ? digits_held + 1'b1 : digits_held;
  assign value_add  = (digits_held < CNT_W'(CODE_DIGITS)) ? times_ten[CODE_W-1:0]
                                                           : entry_value;

  // first configured code matching the value after this digit
  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = USER_COUNT - 1; i >= 0; i--) begin
      if (value_add == cfg.user_code[i]) begin
        match_found = 1'b1;
        match_idx   = 2'(i);
      end
    end
  end

  always_comb begin
    mode_next     = mode_reg;
    msg_next      = last_message;
    value_next    = entry_value;
    digits_next   = digits_held;
    elapsed_next  = elapsed_inc;
    failures_next = failures;
    on_next       = outputs_on;
    user_next     = last_user;

    if (item.emergency) begin
      mode_next    = MODE_HOLD;
      on_next      = 1'b1;
      msg_next     = MSG_EMERG;
      elapsed_next = '0;
    end else begin
      case (mode_reg)
        MODE_ENTRY: begin
          if (digits_held != '0 && 32'(elapsed_inc) > 32'(cfg.entry_timeout)) begin
            value_next  = '0;
            digits_next = '0;
            msg_next    = MSG_ENTER;
          end else if (item.key_valid) begin
            elapsed_next = '0;
            if (item.key_code <= KEY_LAST_DIGIT) begin
              value_next  = value_add;
              digits_next = digits_add;
              msg_next    = MSG_SHOW;
              if (digits_add >= CNT_W'(CODE_DIGITS)) begin
                mode_next = MODE_HOLD;
                if (match_found) begin
                  user_next     = match_idx;
                  failures_next = '0;
                  on_next       = 1'b1;
                  msg_next      = MSG_WELCOME;
                end else begin
                  failures_next = (failures != FAIL_MAX) ? failures + 1'b1 : failures;
                  msg_next      = MSG_DENIED;
                end
              end
            end else if (item.key_code == KEY_STAR && digits_held != '0) begin
              value_next  = value_div10;
              digits_next = digits_held - 1'b1;
              msg_next    = (digits_held != CNT_W'(1)) ? MSG_SHOW : MSG_ENTER;
            end
          end
        end
        MODE_HOLD: begin
          if (32'(elapsed_inc) >= 32'(cfg.hold)) begin
            on_next      = 1'b0;
            value_next   = '0;
            digits_next  = '0;
            elapsed_next = '0;
            if (failures >= cfg.max_failures) begin
              mode_next = MODE_LOCK;
              msg_next  = MSG_LOCKED;
            end else begin
              mode_next = MODE_ENTRY;
              msg_next  = MSG_ENTER;
            end
          end
        end
        default: begin
          if (32'(elapsed_inc) >= 32'(cfg.lockout)) begin
            failures_next = '0;
            mode_next     = MODE_ENTRY;
            msg_next      = MSG_ENTER;
            elapsed_next  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_ENTRY;
      last_message <= MSG_ENTER;
      entry_value  <= '0;
      digits_held  <= '0;
      elapsed      <= '0;
      failures     <= '0;
      outputs_on   <= 1'b0;
      last_user    <= '0;
    end else if (accept) begin
      mode_reg     <= mode_next;
      last_message <= msg_next;
      entry_value  <= value_next;
      digits_held  <= digits_next;
      elapsed      <= elapsed_next;
      failures     <= failures_next;
      outputs_on   <= on_next;
      last_user    <= user_next;
    end
  end

  always_comb begin
    result.mode          = mode_next;
    result.message       = msg_next;
    result.entered_value = value_next;
    result.digit_count   = digits_next;
    result.door_open     = on_next;
    result.matched_user  = (msg_next == MSG_WELCOME) ? user_next : 2'd0;
    result.fail_count    = failures_next;
  end

endmodule

// File: rtl/kcl_out_buf.sv
// Result register with a skid stage behind it.
`timescale 1ns / 1ps
module kcl_out_buf
  import kcl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic    skid_valid;
  result_t skid;
  logic    pop;

  assign full = skid_valid;
  assign pop  = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (push) begin
      // skid is empty whenever a beat is pushed
      if (!result_valid || pop) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= skid_valid;
      skid_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!result_valid || pop) begin
        result <= push_data;
      end else begin
        skid <= push_data;
      end
    end else if (pop && skid_valid) begin
      result <= skid;
    end
  end

endmodule

// File: rtl/keypad_code_lock_top.sv
// Top level of the keypad code lock.
// Each result is registered in the result register, or in the skid stage while the output stalls.
// Throughput: one tick per cycle while the buffer is not full; the state update is one pass through the core.
// A two-entry result buffer lets input keep flowing while one result waits downstream.
// Reset (synchronous, active high) clears the lock state and buffer and restores the
// default codes and timings; no clearing pass is needed.
`timescale 1ns / 1ps
module keypad_code_lock_top
  import kcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  result_t core_result;
  logic    accept;
  logic    buf_full;

  assign item_stall = buf_full;
  assign accept     = item_valid && !item_stall;

  kcl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kcl_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .result (core_result)
  );

  kcl_out_buf u_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .push_data    (core_result),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: rtl/kcl_checker.sv
// Port-level checks for the keypad code lock, bound to the top level.
`timescale 1ns / 1ps
module kcl_checker
  import kcl_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input result_t result
);

  // input backs up only when a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with no result pending");

  a_door_in_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.door_open) |-> (result.mode == MODE_HOLD))
    else $error("door open outside hold");

  a_user_with_welcome: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.matched_user != 2'd0) |-> (result.message == MSG_WELCOME))
    else $error("matched user shown without welcome");

  a_lock_message: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.mode == MODE_LOCK) |->
      (result.message == MSG_LOCKED && !result.door_open))
    else $error("lockout with wrong message or open door");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.digit_count <= CNT_W'(CODE_DIGITS)))
    else $error("digit count beyond code length");

endmodule

bind keypad_code_lock_top kcl_checker u_kcl_checker (.*);
